[sv/assert_macros.svh]
// Assertion macros shared by the frame checksum checker RTL.
// No dependencies; each file that asserts includes this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, held off while rst_ni is low.
`define FCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fcc assertion failed");

// Same, with a message of the caller's choosing.
`define FCC_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

[sv/fcc_pkg.sv]
// Types and constants of the frame checksum checker.
// No dependencies; used by every fcc module.
package fcc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned PosW     = 17;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned OutDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_CMD = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_COMPARE_CMD  = 8'd1;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_SUM_ERR = 2'd1,
    VERDICT_CMD_ERR = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [ByteW-1:0] expected_cmd;
    logic             compare_cmd;
  } cfg_t;

  typedef struct packed {
    verdict_e         verdict;
    logic [ByteW-1:0] frame_command;
    logic [LenW-1:0]  payload_length;
  } result_t;

endpackage

[sv/fcc_cfg_regs.sv]
// Configuration registers of the frame checksum checker.
// Depends on fcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fcc_cfg_regs
  import fcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_EXPECTED_CMD) begin
        cfg_d.expected_cmd = cfg_data_i;
      end else if (cfg_index_i == CFG_COMPARE_CMD) begin
        cfg_d.compare_cmd = cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_cmd <= '0;
      cfg_q.compare_cmd  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  `FCC_ASSERT(a_cmp_write, cfg_valid_i && cfg_index_i == CFG_COMPARE_CMD |=> cfg_q.compare_cmd == $past(cfg_data_i[0]))

endmodule

[sv/fcc_frame_eval.sv]
// Input register, frame tracking state and checksum/command compare.
// Depends on fcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fcc_frame_eval
  import fcc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_start_i,
  input  cfg_t             cfg_i,
  output logic             res_valid_o,
  input  logic             res_space_i,
  output result_t          res_o
);

  logic             in_valid_d, in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;

  logic [PosW-1:0]  pos_d, pos_q;
  logic [LenW-1:0]  len_d, len_q;
  logic [ByteW-1:0] sum_d, sum_q;
  logic [ByteW-1:0] cmd_d, cmd_q;
  logic             active_d, active_q;

  logic [PosW-1:0]  pos_cur;
  logic [LenW-1:0]  len_cur, len_new;
  logic [ByteW-1:0] sum_cur, cmd_cur, cmd_new;
  logic             act_cur, hit, consume, take;
  verdict_e         verdict;

  // Start byte clears the frame state before it is used
  always_comb begin
    act_cur = in_start_q | active_q;
    pos_cur = in_start_q ? '0 : pos_q;
    len_cur = in_start_q ? '0 : len_q;
    sum_cur = in_start_q ? '0 : sum_q;
    cmd_cur = in_start_q ? '0 : cmd_q;

    cmd_new = (pos_cur == PosW'(1)) ? in_byte_q : cmd_cur;
    if (pos_cur == PosW'(2)) begin
      len_new = {in_byte_q, 8'h00};
    end else if (pos_cur == PosW'(3)) begin
      len_new = {len_cur[LenW-1:ByteW], in_byte_q};
    end else begin
      len_new = len_cur;
    end

    hit = act_cur && (pos_cur >= PosW'(3)) && (pos_cur == ({1'b0, len_new} + PosW'(3)));

    if (in_byte_q != sum_cur) begin
      verdict = VERDICT_SUM_ERR;
    end else if (cfg_i.compare_cmd && (cmd_new != cfg_i.expected_cmd)) begin
      verdict = VERDICT_CMD_ERR;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  // Items without a verdict never wait for the output register
  assign consume     = in_valid_q && (res_space_i || !hit);
  assign in_ready_o  = !in_valid_q || consume;
  assign take        = in_valid_i && in_ready_o;
  assign res_valid_o = in_valid_q && hit;
  assign res_o       = '{verdict: verdict, frame_command: cmd_new, payload_length: len_new};

  always_comb begin
    in_valid_d = take ? 1'b1 : (consume ? 1'b0 : in_valid_q);
    pos_d      = pos_q;
    len_d      = len_q;
    sum_d      = sum_q;
    cmd_d      = cmd_q;
    active_d   = active_q;
    if (consume && act_cur) begin
      cmd_d = cmd_new;
      len_d = len_new;
      if (hit) begin
        active_d = 1'b0;
        pos_d    = '0;
        sum_d    = '0;
      end else begin
        active_d = 1'b1;
        pos_d    = pos_cur + PosW'(1);
        sum_d    = sum_cur + in_byte_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      cmd_q      <= '0;
      active_q   <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
      cmd_q      <= cmd_d;
      active_q   <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q  <= in_byte_i;
      in_start_q <= in_start_i;
    end
  end

  `FCC_ASSERT(a_verdict_ends_frame, consume && hit |=> !active_q && pos_q == '0)
  `FCC_ASSERT_MSG(a_pos_bound, active_q |-> pos_q <= ({1'b0, len_q} + PosW'(3)), "position past checksum byte")

endmodule

[sv/fcc_out_stage.sv]
// Output register holding one verdict until the sink takes it.
// Depends on fcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fcc_out_stage
  import fcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  output logic                res_space_o,
  input  result_t             res_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic    full_d, full_q;
  logic    load;
  result_t res_q;

  assign res_space_o = !full_q || m_axis_tready_i;
  assign load        = res_valid_i && res_space_o;

  always_comb begin
    full_d = full_q;
    if (load) begin
      full_d = 1'b1;
    end else if (m_axis_tready_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = full_q;
  assign m_axis_tdata_o  = {(OutDataW - LenW - ByteW - 2)'(0), res_q.payload_length,
                            res_q.frame_command, res_q.verdict};

  `FCC_ASSERT_MSG(a_no_overwrite, full_q && !m_axis_tready_i |-> !load, "verdict overwritten")

endmodule

[sv/frame_checksum_checker.sv]
// Top level of the frame checksum checker.
// Depends on fcc_pkg, fcc_cfg_regs, fcc_frame_eval and fcc_out_stage.

// Frame checksum checker. Takes received frame bytes one item per clock
// (header, command, length high, length low, payload, checksum) and gives
// one verdict item per frame on the checksum byte, i.e. the byte at offset
// length+3; with a zero length that is the length-low byte itself. The
// checksum byte must equal the 8-bit sum of all earlier bytes of the frame;
// a mismatch reports a checksum error, which wins over a command mismatch
// (checked against expected_command only while compare_command is 1). The
// header byte is never checked. tuser marks the first byte of a frame and
// restarts tracking, dropping any unfinished frame silently; bytes outside a
// frame are swallowed. Each byte passes an input register, combinational
// compare logic and an output register; the block sustains one byte per
// clock, and a checksum byte's verdict goes from the input register into
// the output register. Only a stalled output register (m_axis_tready_i low
// with a verdict held) stops intake, and then only for a byte that itself
// closes a frame. Write the configuration only while the block is idle.
module frame_checksum_checker
  import fcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Byte stream in
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,  // [7:0] rx_byte
  input  logic [0:0]          s_axis_tuser_i,  // [0] frame_start
  // Verdicts out
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // [1:0] verdict, [9:2] frame_command,
                                               // [25:10] payload_length, [31:26] zero
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [ByteW-1:0]    cfg_data_i
);

  cfg_t    cfg;
  logic    res_valid;
  logic    res_space;
  result_t res;

  // Hold the two configuration registers
  fcc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Register each byte, advance the frame state and decide the verdict
  fcc_frame_eval u_frame_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_start_i  (s_axis_tuser_i[0]),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_space_i (res_space),
    .res_o       (res)
  );

  // Hold the verdict item until the sink takes it
  fcc_out_stage u_out_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_space_o     (res_space),
    .res_i           (res),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
